@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the rational arithmetic RTL
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define RAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset
`define RAR_ASSERT_NEVER(lbl, expr, msg) \
  `RAR_ASSERT(lbl, !(expr), msg)

`endif

@@ sv/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg
// Types and constants shared by the rational arithmetic reduce core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rar_pkg;

  // datapath and input widths
  localparam int unsigned DW = 32;
  localparam int unsigned IW = 16;

  // operation codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  // which fraction is being reduced
  typedef enum logic [1:0] {
    SEL_P,
    SEL_Q,
    SEL_R
  } red_sel_e;

  // what the divider is fed with
  typedef enum logic [1:0] {
    DSRC_REM,
    DSRC_NUM,
    DSRC_DEN
  } div_src_e;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MP_AD,
    MP_CB,
    MP_AC,
    MP_BD,
    MP_BC
  } mul_pair_e;

  // update of the result numerator
  typedef enum logic [1:0] {
    RN_HOLD,
    RN_SET,
    RN_ADD,
    RN_SUB
  } rn_op_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      gcd_init;
    logic      gcd_step;
    logic      div_start;
    div_src_e  div_src;
    red_sel_e  sel;
    logic      wr_num;
    logic      wr_den;
    mul_pair_e mul_pair;
    rn_op_e    rn_op;
    logic      rd_set;
    logic      out_load;
    logic      out_err;
  } rar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic div_done;
  } rar_sts_t;

endpackage

@@ sv/rar_div.sv @@
// ----------------------------------------------------------------------------
// rar_div
// Unsigned restoring divider, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_div
  import rar_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] div_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = (shifted >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

  `RAR_ASSERT(a_div_no_restart, start_i |-> !busy_q, "divider restarted while busy")
  `RAR_ASSERT(a_div_rem_range, done_q |-> (rem_q < div_q), "remainder not below divisor")

endmodule

@@ sv/rar_dp.sv @@
// ----------------------------------------------------------------------------
// rar_dp
// Datapath: operand and result registers, Euclid sign/magnitude pair,
// shared divider, multiplier and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_dp
  import rar_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rar_cmd_t             cmd_i,
  output rar_sts_t             sts_o,
  input  logic signed [IW-1:0] p_num_i,
  input  logic signed [IW-1:0] p_den_i,
  input  logic signed [IW-1:0] q_num_i,
  input  logic signed [IW-1:0] q_den_i,
  output logic signed [DW-1:0] res_num_o,
  output logic signed [DW-1:0] res_den_o,
  output logic                 zero_gcd_error_o
);

  // magnitude of a two's complement word; -2^31 gives 2^31 unsigned
  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  logic signed [DW-1:0] a_q, b_q, c_q, d_q;
  logic signed [DW-1:0] rn_q, rd_q;
  logic signed [DW-1:0] prod_q;
  logic                 x_neg_q, y_neg_q;
  logic [DW-1:0]        x_mag_q, y_mag_q;
  logic signed [DW-1:0] res_num_q, res_den_q;
  logic                 err_q;

  logic [DW-1:0]        n_sel, d_sel;
  logic [DW-1:0]        dvd, dvs;
  logic [DW-1:0]        quot, rem;
  logic                 div_done;
  logic [DW-1:0]        q_num_s, q_den_s;
  logic signed [DW-1:0] m1, m2;
  logic signed [2*DW-1:0] mul_full;

  // fraction under reduction
  always_comb begin
    unique case (cmd_i.sel)
      SEL_P:   begin n_sel = a_q;  d_sel = b_q;  end
      SEL_Q:   begin n_sel = c_q;  d_sel = d_q;  end
      SEL_R:   begin n_sel = rn_q; d_sel = rd_q; end
      default: begin n_sel = a_q;  d_sel = b_q;  end
    endcase
  end

  // divider operands
  always_comb begin
    unique case (cmd_i.div_src)
      DSRC_REM: begin dvd = x_mag_q;       dvs = y_mag_q; end
      DSRC_NUM: begin dvd = mag_of(n_sel); dvs = x_mag_q; end
      DSRC_DEN: begin dvd = mag_of(d_sel); dvs = x_mag_q; end
      default:  begin dvd = x_mag_q;       dvs = y_mag_q; end
    endcase
  end

  rar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // signed quotients by the gcd; the sign rule of truncating division
  assign q_num_s = (n_sel[DW-1] ^ x_neg_q) ? (~quot + 1'b1) : quot;
  assign q_den_s = (d_sel[DW-1] ^ x_neg_q) ? (~quot + 1'b1) : quot;

  // multiplier operand pairs
  always_comb begin
    unique case (cmd_i.mul_pair)
      MP_AD:   begin m1 = a_q; m2 = d_q; end
      MP_CB:   begin m1 = c_q; m2 = b_q; end
      MP_AC:   begin m1 = a_q; m2 = c_q; end
      MP_BD:   begin m1 = b_q; m2 = d_q; end
      MP_BC:   begin m1 = b_q; m2 = c_q; end
      default: begin m1 = a_q; m2 = d_q; end
    endcase
  end

  assign mul_full = m1 * m2;

  // operand, result and Euclid registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[DW-1:0];

    if (cmd_i.load) begin
      a_q <= {{(DW-IW){p_num_i[IW-1]}}, p_num_i};
      b_q <= {{(DW-IW){p_den_i[IW-1]}}, p_den_i};
      c_q <= {{(DW-IW){q_num_i[IW-1]}}, q_num_i};
      d_q <= {{(DW-IW){q_den_i[IW-1]}}, q_den_i};
    end

    // Euclid pair: x holds the gcd once y reaches zero
    if (cmd_i.gcd_init) begin
      x_neg_q <= n_sel[DW-1];
      x_mag_q <= mag_of(n_sel);
      y_neg_q <= d_sel[DW-1];
      y_mag_q <= mag_of(d_sel);
    end else if (cmd_i.gcd_step) begin
      x_neg_q <= y_neg_q;
      x_mag_q <= y_mag_q;
      y_neg_q <= x_neg_q;
      y_mag_q <= rem;
    end

    if (cmd_i.wr_num) begin
      unique case (cmd_i.sel)
        SEL_P:   a_q  <= q_num_s;
        SEL_Q:   c_q  <= q_num_s;
        SEL_R:   rn_q <= q_num_s;
        default: a_q  <= q_num_s;
      endcase
    end
    if (cmd_i.wr_den) begin
      unique case (cmd_i.sel)
        SEL_P:   b_q  <= q_den_s;
        SEL_Q:   d_q  <= q_den_s;
        SEL_R:   rd_q <= q_den_s;
        default: b_q  <= q_den_s;
      endcase
    end

    // cross products, wrapping to 32 bits
    unique case (cmd_i.rn_op)
      RN_SET:  rn_q <= prod_q;
      RN_ADD:  rn_q <= rn_q + prod_q;
      RN_SUB:  rn_q <= rn_q - prod_q;
      default: ;
    endcase
    if (cmd_i.rd_set) begin
      rd_q <= prod_q;
    end

    // output register; a zero gcd forces 0/0
    if (cmd_i.out_load) begin
      res_num_q <= cmd_i.out_err ? '0 : rn_q;
      res_den_q <= cmd_i.out_err ? '0 : rd_q;
      err_q     <= cmd_i.out_err;
    end
  end

  assign sts_o.x_zero   = (x_mag_q == '0);
  assign sts_o.y_zero   = (y_mag_q == '0);
  assign sts_o.div_done = div_done;

  assign res_num_o        = res_num_q;
  assign res_den_o        = res_den_q;
  assign zero_gcd_error_o = err_q;

  `RAR_ASSERT(a_dp_divisor_nz, cmd_i.div_start |-> (dvs != '0), "divider started with zero divisor")

endmodule

@@ sv/rar_ctrl.sv @@
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer: three Euclid reductions, quotient divisions and the cross
// product steps, plus the input and output handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rar_ctrl
  import rar_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rar_cmd_t   cmd_o,
  input  rar_sts_t   sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GINIT,
    S_GTEST,
    S_GDIV,
    S_NDIV,
    S_DDIV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN
  } state_e;

  state_e     state_q;
  red_sel_e   sel_q;
  logic [1:0] func_q;
  logic       err_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // command decode
  always_comb begin
    cmd_o         = '0;
    cmd_o.sel     = sel_q;
    cmd_o.out_err = err_q;
    unique case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_GINIT: cmd_o.gcd_init = 1'b1;
      S_GTEST: begin
        cmd_o.div_start = !(sts_i.y_zero && sts_i.x_zero);
        cmd_o.div_src   = sts_i.y_zero ? DSRC_NUM : DSRC_REM;
      end
      S_GDIV:  begin
        cmd_o.gcd_step = sts_i.div_done;
        cmd_o.div_src  = DSRC_REM;
      end
      S_NDIV:  begin
        cmd_o.wr_num    = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_src   = DSRC_DEN;
      end
      S_DDIV:  begin
        cmd_o.wr_den  = sts_i.div_done;
        cmd_o.div_src = DSRC_DEN;
      end
      S_MUL0:  cmd_o.mul_pair = (func_q == FUNC_MUL) ? MP_AC : MP_AD;
      S_MUL1:  begin
        cmd_o.mul_pair = MP_CB;
        cmd_o.rn_op    = RN_SET;
      end
      S_MUL2:  begin
        cmd_o.mul_pair = (func_q == FUNC_DIV) ? MP_BC : MP_BD;
        if (func_q == FUNC_ADD) begin
          cmd_o.rn_op = RN_ADD;
        end else if (func_q == FUNC_SUB) begin
          cmd_o.rn_op = RN_SUB;
        end
      end
      S_MUL3:  cmd_o.rd_set = 1'b1;
      S_FIN:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= SEL_P;
      func_q      <= FUNC_ADD;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            sel_q   <= SEL_P;
            err_q   <= 1'b0;
            state_q <= S_GINIT;
          end
        end
        S_GINIT: state_q <= S_GTEST;
        S_GTEST: begin
          if (sts_i.y_zero && sts_i.x_zero) begin
            err_q   <= 1'b1;
            state_q <= S_FIN;
          end else if (sts_i.y_zero) begin
            state_q <= S_NDIV;
          end else begin
            state_q <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (sts_i.div_done) begin
            state_q <= S_GTEST;
          end
        end
        S_NDIV: begin
          if (sts_i.div_done) begin
            state_q <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (sts_i.div_done) begin
            unique case (sel_q)
              SEL_P: begin
                sel_q   <= SEL_Q;
                state_q <= S_GINIT;
              end
              SEL_Q:   state_q <= S_MUL0;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_MUL3;
        S_MUL3: begin
          sel_q   <= SEL_R;
          state_q <= S_GINIT;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `RAR_ASSERT(a_ctrl_done_waited,
    sts_i.div_done |-> (state_q == S_GDIV || state_q == S_NDIV || state_q == S_DDIV),
    "divider finished outside a wait state")
  `RAR_ASSERT_NEVER(a_ctrl_load_overrun, cmd_o.out_load && out_valid_q && out_stall_i,
    "result register overwritten while stalled")

endmodule

@@ sv/rational_arith_reduce_core.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce_core
// Adds, subtracts, multiplies or divides two 16-bit fractions, reducing both
// operands and the result by a signed Euclid gcd.
//
//   channel | direction | handshake                | beat payload
//   in      | input     | in_valid_i / in_stall_o   | func, p_num, p_den, q_num, q_den
//   out     | output    | out_valid_o / out_stall_i | res_num, res_den, zero_gcd_error
//
// One item at a time. Each Euclid remainder step runs on the shared 32-step
// divider; a reduction is its Euclid steps plus two quotient divisions; an
// item is three reductions, the cross product states S_MUL0 to S_MUL3 and
// the handshake states S_IDLE and S_FIN. A zero gcd ends the item early.
// Reset clears control only. in_stall_o is high from acceptance until the
// result is registered; a stalled output holds the next result in the last state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arith_reduce_core
  import rar_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic signed [IW-1:0] p_num_i,
  input  logic signed [IW-1:0] p_den_i,
  input  logic signed [IW-1:0] q_num_i,
  input  logic signed [IW-1:0] q_den_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DW-1:0] res_num_o,
  output logic signed [DW-1:0] res_den_o,
  output logic                 zero_gcd_error_o
);

  rar_cmd_t cmd;
  rar_sts_t sts;

  rar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rar_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .p_num_i          (p_num_i),
    .p_den_i          (p_den_i),
    .q_num_i          (q_num_i),
    .q_den_i          (q_den_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_gcd_error_o (zero_gcd_error_o)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rational_arith_reduce_core. Each accepted beat is
// run through a local model of the gcd reduction and cross products, and the
// expected fraction is queued. Every result beat is checked field by field
// against the oldest entry. Directed beats cover each operation, zero terms
// and the 16-bit extremes. Random beats follow, with random gaps on the input
// and random output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rar_pkg::*;

  localparam int IDLE_LIMIT  = 100_000;
  localparam int RANDOM_BEATS = 160;
  localparam int STEADY_BEATS = 20;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
    logic                 err;
  } ratio_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i     = FUNC_ADD;
  logic signed [IW-1:0] p_num_i    = '0;
  logic signed [IW-1:0] p_den_i    = '0;
  logic signed [IW-1:0] q_num_i    = '0;
  logic signed [IW-1:0] q_den_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [DW-1:0] res_num_o;
  logic signed [DW-1:0] res_den_o;
  logic                 zero_gcd_error_o;

  ratio_t pending_ratios[$];
  int     n_fail     = 0;
  bit     steady     = 1'b0;   // no gaps and no stall while set
  int     stall_left = 0;

  rational_arith_reduce_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .p_num_i          (p_num_i),
    .p_den_i          (p_den_i),
    .q_num_i          (q_num_i),
    .q_den_i          (q_den_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_gcd_error_o (zero_gcd_error_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fraction model
  // ---------------------------------------------------------------------------

  // keep the low 32 bits, sign extended
  function automatic longint trunc32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  // divide n/d by the truncating-remainder Euclid gcd; 0 when the gcd is zero
  function automatic bit cancel_gcd(inout longint n, inout longint d);
    longint x, y, t;
    x = n;
    y = d;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    if (x == 0) return 1'b0;
    n = trunc32(n / x);
    d = trunc32(d / x);
    return 1'b1;
  endfunction

  function automatic ratio_t calc_ratio(logic [1:0] op, logic signed [IW-1:0] pn, pd, qn, qd);
    longint a, b, c, d, rn, rd;
    bit     ok;
    ratio_t r;
    a  = pn;
    b  = pd;
    c  = qn;
    d  = qd;
    rn = 0;
    rd = 0;
    ok = cancel_gcd(a, b);
    ok = cancel_gcd(c, d) && ok;
    if (ok) begin
      case (op)
        FUNC_ADD: begin
          rn = a * d + c * b;
          rd = b * d;
        end
        FUNC_SUB: begin
          rn = a * d - c * b;
          rd = b * d;
        end
        FUNC_MUL: begin
          rn = a * c;
          rd = b * d;
        end
        default: begin
          rn = a * d;
          rd = b * c;
        end
      endcase
      rn = trunc32(rn);
      rd = trunc32(rd);
      ok = cancel_gcd(rn, rd);
    end
    if (!ok) begin
      rn = 0;
      rd = 0;
    end
    r.num = rn[31:0];
    r.den = rd[31:0];
    r.err = !ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one operand term: zero, extreme, factor-rich or fully random
  function automatic logic signed [IW-1:0] rand_term();
    int sel, base, mult, k;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h8001;
        2:       return 16'h7fff;
        3:       return 16'h0001;
        default: return 16'hffff;
      endcase
    end
    if (sel < 5) begin
      base = $urandom_range(0, 200);
      base = base - 100;
      mult = $urandom_range(1, 300);
      k    = base * mult;
      return k[15:0];
    end
    raw = $urandom();
    return raw[15:0];
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_ratio(input logic [1:0] op, input logic signed [IW-1:0] pn, pd, qn, qd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    p_num_i    <= pn;
    p_den_i    <= pd;
    q_num_i    <= qn;
    q_den_i    <= qd;
    do @(posedge clk_i); while (in_stall_o);
    pending_ratios.push_back(calc_ratio(op, pn, pd, qn, qd));
  endtask

  // hold the input off until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ratios.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_each_func();
    send_ratio(FUNC_ADD, 6, 8, -10, 15);
    send_ratio(FUNC_SUB, 6, 8, -10, 15);
    send_ratio(FUNC_MUL, 6, 8, -10, 15);
    send_ratio(FUNC_DIV, 6, 8, -10, 15);
  endtask

  task automatic test_zero_terms();
    send_ratio(FUNC_ADD, 0, 0, 3, 4);     // zero over zero in p
    send_ratio(FUNC_MUL, 5, 7, 0, 0);     // zero over zero in q
    send_ratio(FUNC_MUL, 0, 5, 4, 0);     // result is zero over zero
    send_ratio(FUNC_ADD, 7, 0, -3, 0);    // n/0 terms collapse to 1/0
    send_ratio(FUNC_DIV, -6, 0, 0, 3);
    send_ratio(FUNC_SUB, 0, -9, 5, 6);    // 0/d becomes 0/1
    send_ratio(FUNC_DIV, 2, 3, 0, 4);
  endtask

  task automatic test_extremes();
    send_ratio(FUNC_MUL, 16'h8000, 16'hffff, 16'h8000, 16'hffff);
    send_ratio(FUNC_DIV, 16'hffff, 16'h8000, 16'h8000, 16'hffff);
    send_ratio(FUNC_ADD, 16'h8000, 16'h8001, 16'h8000, 16'h7fff);
    send_ratio(FUNC_SUB, 16'h7fff, 16'h8000, 16'h8001, 16'h7fff);
    send_ratio(FUNC_MUL, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);
    send_ratio(FUNC_ADD, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    send_ratio(FUNC_DIV, 16'h0001, 16'h8000, 16'h8000, 16'h0001);
    send_ratio(FUNC_SUB, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
  endtask

  // random beats; halfway the input waits for the output side to empty
  task automatic test_random(input int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      op = 2'($urandom_range(0, 3));
      send_ratio(op, rand_term(), rand_term(), rand_term(), rand_term());
    end
  endtask

  // back-to-back beats with the output never stalled
  task automatic test_steady(input int n);
    logic [1:0] op;
    steady = 1'b1;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(0, 3));
      send_ratio(op, rand_term(), rand_term(), rand_term(), rand_term());
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output stall: runs of random length, separated by open cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expected fraction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ratio_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ratios.size() == 0) begin
        $error("result beat with nothing expected: %0d/%0d err %0b",
               res_num_o, res_den_o, zero_gcd_error_o);
        n_fail++;
      end else begin
        want = pending_ratios.pop_front();
        if (res_num_o !== want.num) begin
          $error("res_num: expected %0d, got %0d", want.num, res_num_o);
          n_fail++;
        end
        if (res_den_o !== want.den) begin
          $error("res_den: expected %0d, got %0d", want.den, res_den_o);
          n_fail++;
        end
        if (zero_gcd_error_o !== want.err) begin
          $error("zero_gcd_error: expected %0b, got %0b", want.err, zero_gcd_error_o);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no beat on either side
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("timeout: no beat for %0d cycles, %0d results outstanding",
           IDLE_LIMIT, pending_ratios.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_each_func();
    test_zero_terms();
    test_extremes();
    test_random(RANDOM_BEATS);
    test_steady(STEADY_BEATS);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && pending_ratios.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
